// ----- design/pcrd_pkg.sv -----
// pcrd_pkg: types, constants and table functions for the pucch common resource block
// used by pcrd_index_div and pucch_common_resource_derive; no dependencies
package pcrd_pkg;

  localparam int unsigned NSYMB_SLOT  = 14;
  localparam int unsigned PRB_PER_CCE = 6;
  localparam int unsigned MAX_INDEX   = 15;
  // reciprocal of PRB_PER_CCE in q12, exact for all 9-bit bwp sizes
  localparam int unsigned RECIP6_Q12  = 683;
  localparam int unsigned RECIP_SHIFT = 12;

  localparam int unsigned CCE_W   = 8;
  localparam int unsigned PRI_W   = 3;
  localparam int unsigned ROW_W   = 4;
  localparam int unsigned PRB_W   = 9;
  localparam int unsigned NCCE_W  = 7;
  localparam int unsigned SYM_W   = 4;
  localparam int unsigned CS_W    = 4;
  localparam int unsigned RIDX_W  = 4;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [ROW_W-1:0] ROW_QUARTER_OFFSET = 4'd15;
  localparam logic [ROW_W-1:0] ROW_ALT_SHIFT      = 4'd0;

  typedef enum logic [0:0] {
    CFG_COMMON_ROW = 1'b0,
    CFG_BWP_PRBS   = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_CCE  = 2'd1,
    ST_BIG_INDEX = 2'd2,
    ST_PRB_OUT   = 2'd3
  } status_t;

  typedef struct packed {
    logic             fmt;
    logic [SYM_W-1:0] start;
    logic [2:0]       offset;
    logic [2:0]       ncs;
  } row_entry_t;

  // divider result: resource index and the index-above-15 flag
  typedef struct packed {
    logic              big;
    logic [RIDX_W-1:0] index;
  } div_res_t;

  typedef struct packed {
    logic [1:0] q;
    logic [1:0] c;
  } qc_t;

  function automatic row_entry_t row_lookup(input logic [ROW_W-1:0] row);
    row_entry_t e;
    case (row)
      4'd0:    e = '{1'b0, 4'd12, 3'd0, 3'd2};
      4'd1:    e = '{1'b0, 4'd12, 3'd0, 3'd3};
      4'd2:    e = '{1'b0, 4'd12, 3'd3, 3'd3};
      4'd3:    e = '{1'b1, 4'd10, 3'd0, 3'd2};
      4'd4:    e = '{1'b1, 4'd10, 3'd0, 3'd3};
      4'd5:    e = '{1'b1, 4'd10, 3'd2, 3'd3};
      4'd6:    e = '{1'b1, 4'd10, 3'd4, 3'd3};
      4'd7:    e = '{1'b1, 4'd4,  3'd0, 3'd2};
      4'd8:    e = '{1'b1, 4'd4,  3'd0, 3'd3};
      4'd9:    e = '{1'b1, 4'd4,  3'd2, 3'd3};
      4'd10:   e = '{1'b1, 4'd4,  3'd4, 3'd3};
      4'd11:   e = '{1'b1, 4'd0,  3'd0, 3'd2};
      4'd12:   e = '{1'b1, 4'd0,  3'd0, 3'd4};
      4'd13:   e = '{1'b1, 4'd0,  3'd2, 3'd4};
      4'd14:   e = '{1'b1, 4'd0,  3'd4, 3'd4};
      default: e = '{1'b1, 4'd0,  3'd0, 3'd4};
    endcase
    return e;
  endfunction

  // quotient and remainder of a 3-bit index by a shift set size of 2, 3 or 4
  function automatic qc_t split_index(input logic [2:0] rr, input logic [2:0] ncs);
    qc_t res;
    case (ncs)
      3'd2:    res = '{rr[2:1], {1'b0, rr[0]}};
      3'd4:    res = '{{1'b0, rr[2]}, rr[1:0]};
      default: begin
        case (rr)
          3'd0:    res = '{2'd0, 2'd0};
          3'd1:    res = '{2'd0, 2'd1};
          3'd2:    res = '{2'd0, 2'd2};
          3'd3:    res = '{2'd1, 2'd0};
          3'd4:    res = '{2'd1, 2'd1};
          3'd5:    res = '{2'd1, 2'd2};
          3'd6:    res = '{2'd2, 2'd0};
          default: res = '{2'd2, 2'd1};
        endcase
      end
    endcase
    return res;
  endfunction

  function automatic logic [CS_W-1:0] pick_shift(input logic [ROW_W-1:0] row,
                                                 input logic [2:0]       ncs,
                                                 input logic [1:0]       c);
    logic [CS_W-1:0] cs;
    case (ncs)
      3'd2: begin
        if (c[0]) begin
          cs = (row == ROW_ALT_SHIFT) ? 4'd3 : 4'd6;
        end else begin
          cs = 4'd0;
        end
      end
      3'd4: begin
        case (c)
          2'd0:    cs = 4'd0;
          2'd1:    cs = 4'd3;
          2'd2:    cs = 4'd6;
          default: cs = 4'd9;
        endcase
      end
      default: begin
        case (c)
          2'd1:    cs = 4'd4;
          2'd2:    cs = 4'd8;
          default: cs = 4'd0;
        endcase
      end
    endcase
    return cs;
  endfunction

endpackage

// ----- design/pcrd_index_div.sv -----
// pcrd_index_div: two-stage restoring divider for the resource index
// forms floor(2*first_cce / n_cce) + 2*resource_indicator; uses pcrd_pkg
module pcrd_index_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pcrd_pkg::CCE_W-1:0]    first_cce,
  input  logic [pcrd_pkg::PRI_W-1:0]    pri,
  input  logic [pcrd_pkg::NCCE_W-1:0]   n_cce,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pcrd_pkg::div_res_t            out_res
);
  import pcrd_pkg::*;

  localparam int unsigned DW = CCE_W + 1;

  logic [DW-1:0]       dvd;
  logic [DW+1:0]       d_ext;
  logic                ovf;
  logic [DW:0]         t3, t2, rem3_e, rem2_e;
  logic                q3, q2;
  logic [DW-1:0]       rem2;

  logic                v1_r;
  logic                ovf1_r;
  logic [1:0]          qhi1_r;
  logic [DW-1:0]       rem1_r;
  logic [PRI_W-1:0]    pri1_r;
  logic                ready1, ready2;

  logic [DW:0]         t1, t0, rem1_e;
  logic                q1, q0;
  logic [4:0]          idx_sum;

  logic                v2_r;
  div_res_t            res2_r;

  // stage 1: overflow test against 16*n and the two upper quotient bits
  assign dvd   = {first_cce, 1'b0};
  assign d_ext = {2'b00, dvd};
  assign ovf   = d_ext >= {n_cce, 4'b0000};

  assign t3     = {n_cce, 3'b000};
  assign q3     = {1'b0, dvd} >= t3;
  assign rem3_e = q3 ? ({1'b0, dvd} - t3) : {1'b0, dvd};
  assign t2     = {1'b0, n_cce, 2'b00};
  assign q2     = rem3_e >= t2;
  assign rem2_e = q2 ? (rem3_e - t2) : rem3_e;
  assign rem2   = rem2_e[DW-1:0];

  assign ready2   = !v2_r || out_ready;
  assign ready1   = !v1_r || ready2;
  assign in_ready = ready1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ready1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      ovf1_r <= ovf;
      qhi1_r <= {q3, q2};
      rem1_r <= rem2;
      pri1_r <= pri;
    end
  end

  // stage 2: lower quotient bits and the index sum
  assign t1     = {2'b00, n_cce, 1'b0};
  assign q1     = {1'b0, rem1_r} >= t1;
  assign rem1_e = q1 ? ({1'b0, rem1_r} - t1) : {1'b0, rem1_r};
  assign t0     = {3'b000, n_cce};
  assign q0     = rem1_e >= t0;
  assign idx_sum = {1'b0, qhi1_r, q1, q0} + {1'b0, pri1_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ready2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1_r) begin
      res2_r.big   <= ovf1_r || (idx_sum > 5'(MAX_INDEX));
      res2_r.index <= idx_sum[RIDX_W-1:0];
    end
  end

  assign out_valid = v2_r;
  assign out_res   = res2_r;

endmodule

// ----- design/pucch_common_resource_derive.sv -----
// pucch_common_resource_derive: top level of the pucch common resource derivation
// four-stage pipeline, instantiates pcrd_index_div; uses pcrd_pkg
//
//  channel  | direction | fields (lowest bit first)
//  ---------+-----------+----------------------------------------------------------
//  in_      | request   | first_cce[7:0], resource_indicator[10:8]
//  out_     | result    | pucch_format, start_sym, symbol_count, first_hop_prb,
//           |           | hop2_prb, cyclic_shift, status
//  cfg_     | write     | index 0 common_row, index 1 bwp_prbs
//
// a request passes two divider stages, the hop/shift split and the output register
// one request per cycle is accepted while the output register can move
// a stalled result holds in the output register; each stage keeps its item until the
// next stage has room, so nothing is dropped or repeated
// synchronous active-low reset clears all valid bits, common_row to 0 and bwp_prbs to 48
module pucch_common_resource_derive (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // first_cce[7:0], resource_indicator[10:8], zeros above
  input  logic [pcrd_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // pucch_format[0], start_sym[4:1], symbol_count[8:5], first_hop_prb[17:9],
  // hop2_prb[26:18], cyclic_shift[30:27], status[32:31], zeros above
  output logic [pcrd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_we,
  input  logic [0:0]                            cfg_addr,
  input  logic [pcrd_pkg::PRB_W-1:0]            cfg_wdata
);
  import pcrd_pkg::*;

  localparam int unsigned PROD_W = PRB_W + 10;

  // configuration registers, plus the cce count kept beside bwp_prbs
  logic [ROW_W-1:0]  common_row_r;
  logic [PRB_W-1:0]  bwp_prbs_r;
  logic [NCCE_W-1:0] n_cce_r;
  logic [PROD_W-1:0] ncce_prod;

  // n_cce = bwp / 6 through a q12 reciprocal
  assign ncce_prod = PROD_W'(cfg_wdata) * PROD_W'(RECIP6_Q12);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      common_row_r <= '0;
      bwp_prbs_r   <= PRB_W'(48);
      n_cce_r      <= NCCE_W'(48 / PRB_PER_CCE);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_COMMON_ROW: common_row_r <= cfg_wdata[ROW_W-1:0];
        CFG_BWP_PRBS: begin
          bwp_prbs_r <= cfg_wdata;
          n_cce_r    <= ncce_prod[RECIP_SHIFT +: NCCE_W];
        end
        default: ;
      endcase
    end
  end

  // row data; the user must keep it static while requests are in flight, the block does not enforce it
  row_entry_t       entry;
  logic [PRB_W-1:0] offset;
  logic             zero_cce;

  assign entry    = row_lookup(common_row_r);
  assign offset   = (common_row_r == ROW_QUARTER_OFFSET) ? {2'b00, bwp_prbs_r[PRB_W-1:2]}
                                                        : {6'd0, entry.offset};
  assign zero_cce = (n_cce_r == '0);

  // stages 1 and 2: resource index
  logic     div_valid;
  logic     div_ready;
  div_res_t div_res;

  pcrd_index_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .first_cce (in_tdata[CCE_W-1:0]),
    .pri       (in_tdata[CCE_W +: PRI_W]),
    .n_cce     (n_cce_r),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_res   (div_res)
  );

  // stage 3: split the index into hop side, PRB step and shift slot
  logic             v3_r;
  logic [PRB_W-1:0] near3_r;
  logic             low3_r;
  logic [1:0]       c3_r;
  status_t          st3_r;
  logic             ready3, ready4;
  qc_t              qc;
  status_t          st3_nxt;

  assign qc = split_index(div_res.index[2:0], entry.ncs);

  always_comb begin
    if (zero_cce) begin
      st3_nxt = ST_ZERO_CCE;
    end else if (div_res.big) begin
      st3_nxt = ST_BIG_INDEX;
    end else begin
      st3_nxt = ST_OK;
    end
  end

  assign ready4    = !out_tvalid || out_tready;
  assign ready3    = !v3_r || ready4;
  assign div_ready = ready3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (ready3) begin
      v3_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && div_valid) begin
      near3_r <= offset + {7'd0, qc.q};
      low3_r  <= !div_res.index[RIDX_W-1];
      c3_r    <= qc.c;
      st3_r   <= st3_nxt;
    end
  end

  // stage 4: bwp bound check, mirrored hop, shift pick, output register
  logic             out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;
  logic [PRB_W-1:0] far;
  logic [PRB_W-1:0] first_hop, second_hop;
  logic [CS_W-1:0]  cs;
  logic [SYM_W-1:0] sym_count;
  status_t          st4;

  assign far       = bwp_prbs_r - PRB_W'(1) - near3_r;
  assign sym_count = SYM_W'(NSYMB_SLOT) - entry.start;

  always_comb begin
    st4        = st3_r;
    first_hop  = '0;
    second_hop = '0;
    cs         = '0;
    if (st3_r == ST_OK) begin
      if (near3_r >= bwp_prbs_r) begin
        st4 = ST_PRB_OUT;
      end else begin
        first_hop  = low3_r ? near3_r : far;
        second_hop = low3_r ? far : near3_r;
        cs         = pick_shift(common_row_r, entry.ncs, c3_r);
      end
    end
    out_data_nxt = {7'd0, st4, cs, second_hop, first_hop, sym_count, entry.start, entry.fmt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ready4) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4 && v3_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- tb/tb_pucch_common_resource_derive.sv -----
// tb_pucch_common_resource_derive: self-checking bench for the pucch common resource block
// drives requests and config writes, predicts each result and checks the out_ stream
// depends on pcrd_pkg and pucch_common_resource_derive
module tb_pucch_common_resource_derive;
  timeunit 1ns;
  timeprecision 1ps;

  import pcrd_pkg::*;

  // one result, packed to match out_tdata[32:0], highest field first
  typedef struct packed {
    status_t     status;
    logic [3:0]  cs;
    logic [8:0]  second_prb;
    logic [8:0]  first_prb;
    logic [3:0]  nsym;
    logic [3:0]  start;
    logic        fmt;
  } result_t;

  // one directed row: config to run under, request, and a hand-written result if fixed
  typedef struct packed {
    logic [3:0]  row;
    logic [8:0]  bwp;
    logic [7:0]  cce;
    logic [2:0]  pri;
    logic        fixed;
    result_t     res;
  } dir_vec_t;

  // common table 9.2.1-1, per row
  localparam int unsigned ROW_START [16] = '{12, 12, 12, 10, 10, 10, 10, 4,
                                             4, 4, 4, 0, 0, 0, 0, 0};
  localparam int unsigned ROW_OFFSET [16] = '{0, 0, 3, 0, 0, 2, 4, 0,
                                              0, 2, 4, 0, 0, 2, 4, 0};
  localparam int unsigned ROW_NCS [16] = '{2, 3, 3, 2, 3, 3, 3, 2,
                                           3, 3, 3, 2, 4, 4, 4, 4};
  localparam int unsigned SHIFT3 [3] = '{0, 4, 8};
  localparam int unsigned SHIFT4 [4] = '{0, 3, 6, 9};
  // bwp sizes worth a phase of their own: no cce, one cce, edges of range and width
  localparam int unsigned BWP_EDGES [10] = '{0, 1, 5, 6, 7, 8, 12, 275, 276, 511};

  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 160;
  localparam int PIPE_SLACK  = 6;   // drain margin after the last result

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [0:0]             cfg_addr   = CFG_COMMON_ROW;
  logic [PRB_W-1:0]       cfg_wdata  = '0;

  // bench copy of the two registers, tracks every write
  logic [3:0]  cur_row = 4'd0;
  logic [8:0]  cur_bwp = 9'd48;

  // result the request on in_tdata should give; moves with in_tdata
  result_t     req_res = '0;
  result_t     pending_res [$];

  int n_errors   = 0;
  int n_checked  = 0;
  int n_settings = 1;
  int status_seen [4] = '{0, 0, 0, 0};

  // receiver stall pattern state
  int rx_mode = 0;
  int rx_left = 0;

  pucch_common_resource_derive u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("tb_pucch_common_resource_derive NOT OK");
    $finish;
  end

  // bench model of the derivation for one request under a given row and bwp size
  function automatic result_t derive_resource(input logic [3:0] row, input logic [8:0] bwp,
                                              input logic [7:0] cce, input logic [2:0] pri);
    result_t     res;
    int unsigned n_cce, offset, ncs, r, rr, near_prb, far_prb, c;
    bit          low_half;
    res        = '0;
    res.status = ST_OK;
    res.fmt    = (row >= 4'd3);
    res.start  = 4'(ROW_START[row]);
    res.nsym   = 4'(NSYMB_SLOT - ROW_START[row]);
    ncs        = ROW_NCS[row];
    n_cce      = bwp / PRB_PER_CCE;
    // last row takes a quarter of the bwp as its rb offset
    offset     = (row == 4'd15) ? bwp / 4 : ROW_OFFSET[row];
    if (n_cce == 0) begin
      res.status = ST_ZERO_CCE;
    end else begin
      r = (2 * cce) / n_cce + 2 * pri;
      if (r > MAX_INDEX) begin
        res.status = ST_BIG_INDEX;
      end else begin
        // lower half starts at the low edge, upper half at the mirrored edge
        low_half = (r < 8);
        rr       = low_half ? r : r - 8;
        near_prb = offset + rr / ncs;
        c        = rr % ncs;
        if (near_prb >= bwp) begin
          res.status = ST_PRB_OUT;
        end else begin
          far_prb        = bwp - 1 - near_prb;
          res.first_prb  = 9'(low_half ? near_prb : far_prb);
          res.second_prb = 9'(low_half ? far_prb : near_prb);
          case (ncs)
            2:       res.cs = (c == 0) ? 4'd0 : ((row == 4'd0) ? 4'd3 : 4'd6);
            3:       res.cs = 4'(SHIFT3[c]);
            default: res.cs = 4'(SHIFT4[c]);
          endcase
        end
      end
    end
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  // scoreboard: record accepted requests, compare accepted results in order
  always @(posedge clk) begin
    result_t want_res, got_res;
    if (rst_n && in_tvalid && in_tready) begin
      pending_res.push_back(req_res);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got_res = result_t'(out_tdata[32:0]);
      if (pending_res.size() == 0) begin
        $display("%0t: result with no request pending, got %h", $time, got_res);
        n_errors++;
      end else begin
        want_res = pending_res.pop_front();
        check_field("pucch_format",   want_res.fmt,        got_res.fmt);
        check_field("start_sym",      want_res.start,      got_res.start);
        check_field("symbol_count",   want_res.nsym,       got_res.nsym);
        check_field("first_hop_prb",  want_res.first_prb,  got_res.first_prb);
        check_field("hop2_prb",       want_res.second_prb, got_res.second_prb);
        check_field("cyclic_shift",   want_res.cs,         got_res.cs);
        check_field("status",         want_res.status,     got_res.status);
        n_checked++;
        status_seen[want_res.status]++;
      end
    end
  end

  // receiver: changes stall mode every so often, full speed included
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (rx_left % 4 == 0);
    endcase
  end

  // drive one request and hold it until accepted; called and returns at a rising edge
  task automatic send_request(input logic [7:0] cce, input logic [2:0] pri,
                              input logic fixed, input result_t fixed_res);
    in_tdata  <= {{(IN_TDATA_W-11){1'b0}}, pri, cce};
    req_res   <= fixed ? fixed_res : derive_resource(cur_row, cur_bwp, cce, pri);
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop sending and let every outstanding result drain out of the pipe
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // both registers, back to back; only called when the block is idle
  task automatic set_config(input logic [3:0] row, input logic [8:0] bwp);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_COMMON_ROW;
    cfg_wdata <= {5'd0, row};
    @(posedge clk);
    cfg_addr  <= CFG_BWP_PRBS;
    cfg_wdata <= bwp;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_row   = row;
    cur_bwp   = bwp;
    n_settings++;
  endtask

  // directed rows; fixed results are '{status, cs, second, first, nsym, start, fmt}
  dir_vec_t dir_tab [24] = '{
    // reset config, first index
    '{4'd0,  9'd48,  8'd0,   3'd0, 1'b1, '{ST_OK, 4'd0, 9'd47, 9'd0, 4'd2, 4'd12, 1'b0}},
    // row 0 odd shift uses 3 instead of 6
    '{4'd0,  9'd48,  8'd6,   3'd0, 1'b1, '{ST_OK, 4'd3, 9'd47, 9'd0, 4'd2, 4'd12, 1'b0}},
    // largest cce and indicator, index far above 15
    '{4'd0,  9'd48,  8'd255, 3'd7, 1'b1, '{ST_BIG_INDEX, 4'd0, 9'd0, 9'd0, 4'd2, 4'd12, 1'b0}},
    '{4'd0,  9'd48,  8'd40,  3'd2, 1'b0, '0},
    '{4'd1,  9'd48,  8'd0,   3'd5, 1'b0, '0},
    '{4'd2,  9'd48,  8'd7,   3'd1, 1'b0, '0},
    '{4'd3,  9'd12,  8'd1,   3'd2, 1'b0, '0},
    '{4'd4,  9'd273, 8'd200, 3'd6, 1'b0, '0},
    '{4'd5,  9'd96,  8'd100, 3'd3, 1'b0, '0},
    // one cce and offset 4: hop lands on the bwp edge
    '{4'd6,  9'd6,   8'd0,   3'd3, 1'b1, '{ST_PRB_OUT, 4'd0, 9'd0, 9'd0, 4'd4, 4'd10, 1'b1}},
    '{4'd6,  9'd6,   8'd0,   3'd2, 1'b0, '0},
    // bwp too small for one cce
    '{4'd7,  9'd5,   8'd0,   3'd0, 1'b1, '{ST_ZERO_CCE, 4'd0, 9'd0, 9'd0, 4'd10, 4'd4, 1'b1}},
    '{4'd8,  9'd30,  8'd4,   3'd1, 1'b0, '0},
    '{4'd9,  9'd100, 8'd0,   3'd4, 1'b0, '0},
    '{4'd10, 9'd7,   8'd0,   3'd3, 1'b0, '0},
    '{4'd11, 9'd0,   8'd255, 3'd7, 1'b1, '{ST_ZERO_CCE, 4'd0, 9'd0, 9'd0, 4'd14, 4'd0, 1'b1}},
    '{4'd12, 9'd275, 8'd255, 3'd0, 1'b0, '0},
    '{4'd13, 9'd24,  8'd3,   3'd7, 1'b0, '0},
    // widest bwp value, beyond the nominal range
    '{4'd14, 9'd511, 8'd170, 3'd2, 1'b0, '0},
    '{4'd15, 9'd511, 8'd85,  3'd5, 1'b0, '0},
    // row 15 offset from a quarter of the bwp
    '{4'd15, 9'd275, 8'd0,   3'd0, 1'b0, '0},
    '{4'd15, 9'd275, 8'd45,  3'd7, 1'b1, '{ST_BIG_INDEX, 4'd0, 9'd0, 9'd0, 4'd14, 4'd0, 1'b1}},
    '{4'd15, 9'd6,   8'd0,   3'd0, 1'b0, '0},
    '{4'd15, 9'd1,   8'd255, 3'd0, 1'b1, '{ST_ZERO_CCE, 4'd0, 9'd0, 9'd0, 4'd14, 4'd0, 1'b1}}
  };

  initial begin
    int          gap, burst, items_left, limit;
    int unsigned n_cce;
    logic [3:0]  row;
    logic [8:0]  bwp;
    logic [7:0]  cce;
    logic [2:0]  pri;

    // reset held, then released once
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows; reconfigure only when the row asks for a new setting
    foreach (dir_tab[i]) begin
      if (dir_tab[i].row != cur_row || dir_tab[i].bwp != cur_bwp) begin
        wait_idle();
        set_config(dir_tab[i].row, dir_tab[i].bwp);
      end
      send_request(dir_tab[i].cce, dir_tab[i].pri, dir_tab[i].fixed, dir_tab[i].res);
      gap = $urandom_range(0, 2);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    // random phases, each under its own setting
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0:       begin row = 4'd15; bwp = 9'd511; end
        1:       begin row = 4'd0;  bwp = 9'd6;   end
        2:       begin row = 4'd6;  bwp = 9'd7;   end
        3:       begin row = 4'd12; bwp = 9'd1;   end
        4:       begin row = 4'd3;  bwp = 9'd275; end
        default: begin
          row = 4'($urandom_range(0, 15));
          case ($urandom_range(0, 9))
            0:       bwp = 9'(BWP_EDGES[$urandom_range(0, 9)]);
            1:       bwp = 9'($urandom_range(276, 511));
            default: bwp = 9'($urandom_range(6, 275));
          endcase
        end
      endcase
      wait_idle();
      set_config(row, bwp);
      n_cce = cur_bwp / PRB_PER_CCE;

      items_left = PHASE_ITEMS;
      while (items_left > 0) begin
        // mostly short bursts, now and then a long one with no idle cycles
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 16);
        for (int k = 0; k < burst && items_left > 0; k++) begin
          pri = 3'($urandom_range(0, 7));
          // three in four requests keep the resource index within the table
          if (n_cce != 0 && $urandom_range(0, 3) != 0) begin
            limit = int'(((16 - 2 * pri) * n_cce - 1) / 2);
            if (limit > 255) limit = 255;
            cce = 8'($urandom_range(0, limit));
          end else begin
            cce = 8'($urandom_range(0, 255));
          end
          send_request(cce, pri, 1'b0, '0);
          items_left--;
          // sender holds off mid-phase until the pipe is empty
          if (phase == 2 && items_left == PHASE_ITEMS / 2) begin
            wait_idle();
          end
        end
        gap = $urandom_range(1, 8);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    // drain and let the pipe settle
    wait_idle();
    repeat (PIPE_SLACK) @(posedge clk);

    $display("run: %0d results checked over %0d register settings", n_checked, n_settings);
    $display("run: status ok %0d, zero cce %0d, index above 15 %0d, prb outside bwp %0d",
             status_seen[ST_OK], status_seen[ST_ZERO_CCE], status_seen[ST_BIG_INDEX],
             status_seen[ST_PRB_OUT]);
    if (n_errors == 0) begin
      $display("tb_pucch_common_resource_derive OK");
    end else begin
      $display("tb_pucch_common_resource_derive NOT OK");
    end
    $finish;
  end

endmodule
